>>> hdl/ged_pkg.sv
// ---------------------------------------------------------------------------
// ged_pkg
// Shared types and constants for the gamepad event decoder.
// ---------------------------------------------------------------------------
package ged_pkg;

    localparam int unsigned TYPE_W  = 16;
    localparam int unsigned CODE_W  = 16;
    localparam int unsigned VALUE_W = 17;
    localparam int unsigned DZ_W    = 15;
    localparam int unsigned TRIG_W  = 16;
    localparam int unsigned HALF_W  = 10;
    localparam int unsigned BTN_W   = 11;
    localparam int unsigned DPAD_W  = 4;
    localparam int unsigned NUM_W   = TRIG_W + HALF_W;

    localparam logic [HALF_W-1:0] SCALE_MAX   = 10'd1023;
    localparam logic [DZ_W-1:0]   DZ_RESET    = 15'd3500;
    localparam logic [TRIG_W-1:0] AXIS_CENTER = 16'd32768;
    localparam logic [TRIG_W-1:0] AXIS_TOP    = 16'd65535;

    // Index of the last quotient bit of a division, one bit per cycle
    localparam logic [3:0] DIV_LAST = 4'(HALF_W - 1);

    localparam logic [CODE_W-1:0] CODE_BTN_B     = 16'd305;
    localparam logic [CODE_W-1:0] CODE_BTN_Y     = 16'd307;
    localparam logic [CODE_W-1:0] CODE_BTN_X     = 16'd306;
    localparam logic [CODE_W-1:0] CODE_BTN_A     = 16'd304;
    localparam logic [CODE_W-1:0] CODE_BTN_LB    = 16'd308;
    localparam logic [CODE_W-1:0] CODE_BTN_RB    = 16'd309;
    localparam logic [CODE_W-1:0] CODE_BTN_START = 16'd311;
    localparam logic [CODE_W-1:0] CODE_BTN_SEL   = 16'd310;
    localparam logic [CODE_W-1:0] CODE_BTN_HOME  = 16'd172;
    localparam logic [CODE_W-1:0] CODE_BTN_LPR   = 16'd312;
    localparam logic [CODE_W-1:0] CODE_BTN_RPR   = 16'd313;
    localparam logic [CODE_W-1:0] CODE_TRIG_L    = 16'd10;
    localparam logic [CODE_W-1:0] CODE_TRIG_R    = 16'd9;
    localparam logic [CODE_W-1:0] CODE_DPAD_Y    = 16'd17;
    localparam logic [CODE_W-1:0] CODE_DPAD_X    = 16'd16;
    localparam logic [CODE_W-1:0] CODE_AXIS_LY   = 16'd1;
    localparam logic [CODE_W-1:0] CODE_AXIS_LX   = 16'd0;
    localparam logic [CODE_W-1:0] CODE_AXIS_RY   = 16'd5;
    localparam logic [CODE_W-1:0] CODE_AXIS_RX   = 16'd2;

    localparam logic [VALUE_W-1:0] VAL_PLUS_ONE  = 17'h00001;
    localparam logic [VALUE_W-1:0] VAL_MINUS_ONE = 17'h1FFFF;

    localparam logic [3:0] BTN_NONE = 4'hF;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_DIVIDE = 5'b00100,
        S_APPLY  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    // Button bit index for a code, BTN_NONE when not a button
    function automatic logic [3:0] btn_index(input logic [CODE_W-1:0] code);
        logic [3:0] idx;
        idx = BTN_NONE;
        if (code == CODE_BTN_B)          idx = 4'd0;
        else if (code == CODE_BTN_Y)     idx = 4'd1;
        else if (code == CODE_BTN_X)     idx = 4'd2;
        else if (code == CODE_BTN_A)     idx = 4'd3;
        else if (code == CODE_BTN_LB)    idx = 4'd4;
        else if (code == CODE_BTN_RB)    idx = 4'd5;
        else if (code == CODE_BTN_START) idx = 4'd6;
        else if (code == CODE_BTN_SEL)   idx = 4'd7;
        else if (code == CODE_BTN_HOME)  idx = 4'd8;
        else if (code == CODE_BTN_LPR)   idx = 4'd9;
        else if (code == CODE_BTN_RPR)   idx = 4'd10;
        return idx;
    endfunction

endpackage

>>> hdl/gamepad_event_decoder_core.sv
// ---------------------------------------------------------------------------
// gamepad_event_decoder_core
// Decodes input events into a controller state snapshot with dead-zone
// mapping of the stick axes.
// ---------------------------------------------------------------------------
// One event is taken at a time. A button, trigger, d-pad, sync or unknown
// event goes through the decode state to the finish state, which loads the
// result into the output register. A stick axis event goes through a decode
// state, the restoring divider that produces one quotient bit per cycle over
// the 10 bits of the scaled magnitude, and an apply state before the finish
// state. The next event is accepted as soon as the result sits in the output
// register, even if it has not been taken yet; a result still waiting there
// holds the following one back until it is taken. The dead zone width may be
// written through cfg_valid/cfg_data while no event is in flight; cfg_ready
// is always high.
module gamepad_event_decoder_core
    import ged_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [DZ_W-1:0]     cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [TYPE_W-1:0]   event_type,
    input  logic [CODE_W-1:0]   event_code,
    input  logic [VALUE_W-1:0]  event_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BTN_W+DPAD_W-1:0] button_bits,
    output logic [TRIG_W-1:0]   left_trigger,
    output logic [TRIG_W-1:0]   right_trigger,
    output logic [HALF_W-1:0]   left_stick_up,
    output logic [HALF_W-1:0]   left_stick_down,
    output logic [HALF_W-1:0]   left_stick_left,
    output logic [HALF_W-1:0]   left_stick_right,
    output logic [HALF_W-1:0]   right_stick_up,
    output logic [HALF_W-1:0]   right_stick_down,
    output logic [HALF_W-1:0]   right_stick_left,
    output logic [HALF_W-1:0]   right_stick_right,
    output logic                updated
);

    // control and state
    state_t               state_reg, state_next;
    logic [DZ_W-1:0]      dz_reg, dz_next;
    logic [BTN_W-1:0]     button_reg, button_next;
    logic [DPAD_W-1:0]    dpad_reg, dpad_next;
    logic [TRIG_W-1:0]    trig_reg [2];
    logic [TRIG_W-1:0]    trig_next [2];
    logic [HALF_W-1:0]    half_reg [8];
    logic [HALF_W-1:0]    half_next [8];
    logic                 upd_reg, upd_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;

    // payload
    logic [TYPE_W-1:0]    ev_type_reg;
    logic [CODE_W-1:0]    ev_code_reg;
    logic [VALUE_W-1:0]   ev_value_reg;
    logic [TRIG_W-2:0]    rem_reg, rem_next;
    logic [HALF_W-1:0]    num_reg, num_next;
    logic [HALF_W-1:0]    quo_reg, quo_next;
    logic [TRIG_W-1:0]    div_reg, div_next;
    logic                 zero_reg, zero_next;
    logic                 full_reg, full_next;
    logic [2:0]           sel_reg, sel_next;
    logic [2:0]           oth_reg, oth_next;
    logic [BTN_W+DPAD_W-1:0] o_btn_reg;
    logic [TRIG_W-1:0]    o_trig_reg [2];
    logic [HALF_W-1:0]    o_half_reg [8];
    logic                 o_upd_reg;
    logic                 load_out;

    // decode-stage helpers
    logic [TRIG_W-1:0]    clamped;
    logic                 lower;
    logic [TRIG_W-1:0]    thr_lo, thr_hi, span;
    logic [TRIG_W-1:0]    excess;
    logic [NUM_W-1:0]     prod;
    logic [3:0]           bidx;
    logic                 is_axis;
    logic [2:0]           ax_base;
    logic [TRIG_W-1:0]    trial;
    logic [TRIG_W-1:0]    diff;
    logic                 ge;
    logic [HALF_W-1:0]    mag;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        // clamp to 0..65535: negative gives zero, positive range already fits
        clamped = ev_value_reg[VALUE_W-1] ? '0 : ev_value_reg[TRIG_W-1:0];
        lower   = ~clamped[TRIG_W-1];
        thr_lo  = AXIS_CENTER - TRIG_W'(dz_reg);
        thr_hi  = AXIS_CENTER + TRIG_W'(dz_reg);
        span    = AXIS_TOP - thr_hi;
        if (lower)
            excess = (clamped > thr_lo) ? '0 : (thr_lo - clamped);
        else
            excess = (clamped < thr_hi) ? '0 : (clamped - thr_hi);
        prod    = NUM_W'(excess) * NUM_W'(SCALE_MAX);
        bidx    = btn_index(ev_code_reg);
        is_axis = 1'b1;
        ax_base = 3'd0;
        unique case (ev_code_reg)
            CODE_AXIS_LY: ax_base = 3'd0;
            CODE_AXIS_LX: ax_base = 3'd2;
            CODE_AXIS_RY: ax_base = 3'd4;
            CODE_AXIS_RX: ax_base = 3'd6;
            default:      is_axis = 1'b0;
        endcase
        trial = {rem_reg, num_reg[HALF_W-1]};
        diff  = trial - div_reg;
        ge    = (trial >= div_reg);
        mag   = full_reg ? SCALE_MAX : (zero_reg ? '0 : quo_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        dz_next        = dz_reg;
        button_next    = button_reg;
        dpad_next      = dpad_reg;
        trig_next      = trig_reg;
        half_next      = half_reg;
        upd_next       = upd_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        zero_next      = zero_reg;
        full_next      = full_reg;
        sel_next       = sel_reg;
        oth_next       = oth_reg;
        load_out       = 1'b0;

        if (cfg_valid)
            dz_next = cfg_data;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                upd_next   = (ev_type_reg != '0);
                if (ev_type_reg != '0)
                begin
                    if (bidx != BTN_NONE)
                        button_next[bidx] = (ev_value_reg != '0);
                    if (ev_code_reg == CODE_TRIG_L)
                        trig_next[0] = clamped;
                    if (ev_code_reg == CODE_TRIG_R)
                        trig_next[1] = clamped;
                    if (ev_code_reg == CODE_DPAD_Y)
                    begin
                        dpad_next[1] = (ev_value_reg == VAL_PLUS_ONE);
                        dpad_next[0] = (ev_value_reg == VAL_MINUS_ONE);
                    end
                    if (ev_code_reg == CODE_DPAD_X)
                    begin
                        dpad_next[3] = (ev_value_reg == VAL_PLUS_ONE);
                        dpad_next[2] = (ev_value_reg == VAL_MINUS_ONE);
                    end
                    if (is_axis)
                    begin
                        state_next = S_DIVIDE;
                        sel_next   = lower ? ax_base : ax_base + 3'd1;
                        oth_next   = lower ? ax_base + 3'd1 : ax_base;
                        div_next   = lower ? thr_lo : span;
                        zero_next  = (excess == '0);
                        // no upper span: any value past the threshold is full scale
                        full_next  = !lower && (span == '0) && (clamped >= thr_hi);
                        // quotient fits 10 bits, so the top bits start below the divisor
                        rem_next   = prod[NUM_W-2:HALF_W];
                        num_next   = prod[HALF_W-1:0];
                        quo_next   = '0;
                        cnt_next   = '0;
                    end
                end
            end
            S_DIVIDE:
            begin
                rem_next = ge ? diff[TRIG_W-2:0] : trial[TRIG_W-2:0];
                num_next = {num_reg[HALF_W-2:0], 1'b0};
                quo_next = {quo_reg[HALF_W-2:0], ge};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                half_next[oth_reg] = '0;
                half_next[sel_reg] = mag;
                upd_next           = (mag != half_reg[sel_reg]);
                state_next         = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dz_reg        <= DZ_RESET;
            button_reg    <= '0;
            dpad_reg      <= '0;
            trig_reg      <= '{default: '0};
            half_reg      <= '{default: '0};
            upd_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dz_reg        <= dz_next;
            button_reg    <= button_next;
            dpad_reg      <= dpad_next;
            trig_reg      <= trig_next;
            half_reg      <= half_next;
            upd_reg       <= upd_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ev_type_reg  <= event_type;
            ev_code_reg  <= event_code;
            ev_value_reg <= event_value;
        end
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
        zero_reg <= zero_next;
        full_reg <= full_next;
        sel_reg  <= sel_next;
        oth_reg  <= oth_next;
        if (load_out)
        begin
            o_btn_reg  <= {dpad_reg, button_reg};
            o_trig_reg <= trig_reg;
            o_half_reg <= half_reg;
            o_upd_reg  <= upd_reg;
        end
    end

    assign button_bits       = o_btn_reg;
    assign left_trigger      = o_trig_reg[0];
    assign right_trigger     = o_trig_reg[1];
    assign left_stick_up     = o_half_reg[0];
    assign left_stick_down   = o_half_reg[1];
    assign left_stick_left   = o_half_reg[2];
    assign left_stick_right  = o_half_reg[3];
    assign right_stick_up    = o_half_reg[4];
    assign right_stick_down  = o_half_reg[5];
    assign right_stick_left  = o_half_reg[6];
    assign right_stick_right = o_half_reg[7];
    assign updated           = o_upd_reg;

endmodule

>>> hdl/gamepad_event_decoder_checker.sv
// ---------------------------------------------------------------------------
// gamepad_event_decoder_checker
// Port-level assertions for the gamepad event decoder, bound to the core.
// ---------------------------------------------------------------------------
module gamepad_event_decoder_checker
    import ged_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [BTN_W+DPAD_W-1:0] button_bits,
    input logic [HALF_W-1:0]   left_stick_up,
    input logic [HALF_W-1:0]   left_stick_down,
    input logic [HALF_W-1:0]   left_stick_left,
    input logic [HALF_W-1:0]   left_stick_right,
    input logic [HALF_W-1:0]   right_stick_up,
    input logic [HALF_W-1:0]   right_stick_down,
    input logic [HALF_W-1:0]   right_stick_left,
    input logic [HALF_W-1:0]   right_stick_right,
    input logic                updated
);

    // one item in flight: in_ready is low in the cycle after an item is accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted back to back");

    // a stalled result holds: out_valid, button_bits, updated and left_stick_up stay
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(button_bits)
            && $stable(updated) && $stable(left_stick_up))
        else $error("stalled result changed");

    // the two halves of one axis are never both active
    a_left_halves: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((left_stick_up != '0) && (left_stick_down != '0))
            && !((left_stick_left != '0) && (left_stick_right != '0)))
        else $error("left stick halves both nonzero");

    a_right_halves: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((right_stick_up != '0) && (right_stick_down != '0))
            && !((right_stick_left != '0) && (right_stick_right != '0)))
        else $error("right stick halves both nonzero");

endmodule

bind gamepad_event_decoder_core gamepad_event_decoder_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .button_bits       (button_bits),
    .left_stick_up     (left_stick_up),
    .left_stick_down   (left_stick_down),
    .left_stick_left   (left_stick_left),
    .left_stick_right  (left_stick_right),
    .right_stick_up    (right_stick_up),
    .right_stick_down  (right_stick_down),
    .right_stick_left  (right_stick_left),
    .right_stick_right (right_stick_right),
    .updated           (updated)
);

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for gamepad_event_decoder_core: a directed event table
// followed by random event streams under several dead zone settings, every
// snapshot checked against a typed-in expectation or a bench-side decoder model.
// ---------------------------------------------------------------------------
module testbench;
    import ged_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_EVENTS = 100;
    localparam int NUM_PHASES   = 5;

    // a code that selects no control
    localparam logic [CODE_W-1:0] CODE_UNUSED = 16'd3;

    typedef struct packed {
        logic [BTN_W+DPAD_W-1:0]   buttons;
        logic [TRIG_W-1:0]         ltrig;
        logic [TRIG_W-1:0]         rtrig;
        logic [7:0][HALF_W-1:0]    half;
        logic                      upd;
    } pad_snapshot_t;

    typedef struct packed {
        logic                      wr_dz;
        logic [DZ_W-1:0]           dz;
        logic [TYPE_W-1:0]         etype;
        logic [CODE_W-1:0]         ecode;
        logic [VALUE_W-1:0]        evalue;
        logic                      typed;
        pad_snapshot_t             exp;
    } event_row_t;

    localparam pad_snapshot_t SNAP_NONE = '0;

    localparam logic [CODE_W-1:0] BUTTON_CODES [11] = '{
        CODE_BTN_B, CODE_BTN_Y, CODE_BTN_X, CODE_BTN_A, CODE_BTN_LB, CODE_BTN_RB,
        CODE_BTN_START, CODE_BTN_SEL, CODE_BTN_HOME, CODE_BTN_LPR, CODE_BTN_RPR
    };
    localparam logic [CODE_W-1:0] AXIS_CODES [4] = '{
        CODE_AXIS_LY, CODE_AXIS_LX, CODE_AXIS_RY, CODE_AXIS_RX
    };
    localparam logic [VALUE_W-1:0] AXIS_EXTREMES [6] = '{
        17'd0, 17'h0FFFF, 17'd32768, 17'd32767, 17'h10000, 17'h1FFFF
    };

    // Expected snapshots are typed in only where they follow directly from reset
    localparam int NUM_ROWS = 25;
    localparam event_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{1'b0, 15'd0, 16'd0, CODE_BTN_B, VAL_PLUS_ONE, 1'b1,
          '{15'h000, 16'd0, 16'd0, 80'd0, 1'b0}},
        '{1'b0, 15'd0, 16'd1, CODE_BTN_B, VAL_PLUS_ONE, 1'b1,
          '{15'h001, 16'd0, 16'd0, 80'd0, 1'b1}},
        '{1'b0, 15'd0, 16'hFFFF, CODE_BTN_HOME, 17'h10000, 1'b1,
          '{15'h101, 16'd0, 16'd0, 80'd0, 1'b1}},
        '{1'b0, 15'd0, 16'd1, CODE_BTN_B, 17'd0, 1'b1,
          '{15'h100, 16'd0, 16'd0, 80'd0, 1'b1}},
        '{1'b0, 15'd0, 16'd1, CODE_BTN_A, 17'h0FFFF, 1'b1,
          '{15'h108, 16'd0, 16'd0, 80'd0, 1'b1}},
        '{1'b0, 15'd0, 16'd1, CODE_BTN_RPR, VAL_PLUS_ONE, 1'b1,
          '{15'h508, 16'd0, 16'd0, 80'd0, 1'b1}},
        '{1'b0, 15'd0, 16'd1, CODE_TRIG_L, 17'h0FFFF, 1'b1,
          '{15'h508, 16'hFFFF, 16'd0, 80'd0, 1'b1}},
        '{1'b0, 15'd0, 16'd1, CODE_TRIG_R, VAL_MINUS_ONE, 1'b1,
          '{15'h508, 16'hFFFF, 16'd0, 80'd0, 1'b1}},
        '{1'b0, 15'd0, 16'd1, CODE_DPAD_Y, VAL_PLUS_ONE, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'd1, CODE_DPAD_Y, VAL_MINUS_ONE, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'd1, CODE_DPAD_Y, 17'd2, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'd1, CODE_DPAD_X, VAL_PLUS_ONE, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'd5, CODE_UNUSED, 17'd77, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'd0, CODE_TRIG_L, 17'd0, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'd1, CODE_AXIS_LY, 17'd0, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'd1, CODE_AXIS_LY, 17'h0FFFF, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'd1, CODE_AXIS_LY, 17'h0FFFF, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'd1, CODE_AXIS_LX, 17'h10000, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'd1, CODE_AXIS_RY, 17'd32768, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'd1, CODE_AXIS_RX, 17'd32767, 1'b0, SNAP_NONE},
        // widest dead zone: upper half has no span
        '{1'b1, 15'h7FFF, 16'd1, CODE_AXIS_RY, 17'h0FFFF, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'd1, CODE_AXIS_RY, 17'd0, 1'b0, SNAP_NONE},
        '{1'b0, 15'd0, 16'd1, CODE_AXIS_RX, 17'd1, 1'b0, SNAP_NONE},
        '{1'b1, 15'd0, 16'd1, CODE_AXIS_LX, 17'd32767, 1'b0, SNAP_NONE}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [DZ_W-1:0]           cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [TYPE_W-1:0]         event_type;
    logic [CODE_W-1:0]         event_code;
    logic [VALUE_W-1:0]        event_value;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [BTN_W+DPAD_W-1:0]   button_bits;
    logic [TRIG_W-1:0]         left_trigger;
    logic [TRIG_W-1:0]         right_trigger;
    logic [HALF_W-1:0]         left_stick_up;
    logic [HALF_W-1:0]         left_stick_down;
    logic [HALF_W-1:0]         left_stick_left;
    logic [HALF_W-1:0]         left_stick_right;
    logic [HALF_W-1:0]         right_stick_up;
    logic [HALF_W-1:0]         right_stick_down;
    logic [HALF_W-1:0]         right_stick_left;
    logic [HALF_W-1:0]         right_stick_right;
    logic                      updated;

    // Decoder model state
    logic [DZ_W-1:0]           cur_dz;
    logic [BTN_W-1:0]          st_buttons;
    logic [DPAD_W-1:0]         st_dpad;
    logic [TRIG_W-1:0]         st_trig [2];
    logic [7:0][HALF_W-1:0]    st_half;

    pad_snapshot_t             expected_snapshots [$];
    logic [VALUE_W-1:0]        last_axis_val [4] = '{default: '0};
    string                     half_names [8] = '{
        "left_stick_up", "left_stick_down", "left_stick_left", "left_stick_right",
        "right_stick_up", "right_stick_down", "right_stick_left", "right_stick_right"
    };

    bit                        steady = 1'b0;
    int                        errors = 0;
    int                        events_sent = 0;
    int                        sync_sent = 0;
    int                        results_checked = 0;
    int                        dz_writes = 0;
    int                        stall_cycles = 0;

    gamepad_event_decoder_core i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .event_type        (event_type),
        .event_code        (event_code),
        .event_value       (event_value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .button_bits       (button_bits),
        .left_trigger      (left_trigger),
        .right_trigger     (right_trigger),
        .left_stick_up     (left_stick_up),
        .left_stick_down   (left_stick_down),
        .left_stick_left   (left_stick_left),
        .left_stick_right  (left_stick_right),
        .right_stick_up    (right_stick_up),
        .right_stick_down  (right_stick_down),
        .right_stick_left  (right_stick_left),
        .right_stick_right (right_stick_right),
        .updated           (updated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [HALF_W-1:0] half_magnitude(bit lower, int unsigned v);
        int unsigned thr;
        int unsigned span;
        int unsigned top;
        top = int'(SCALE_MAX);
        if (lower)
        begin
            thr = int'(AXIS_CENTER) - int'(cur_dz);
            if (v > thr)
                return '0;
            return HALF_W'((top * (thr - v)) / thr);
        end
        thr = int'(AXIS_CENTER) + int'(cur_dz);
        if (v < thr)
            return '0;
        span = int'(AXIS_TOP) - thr;
        if (span == 0)
            return SCALE_MAX;
        return HALF_W'((top * (v - thr)) / span);
    endfunction

    // base is the up/left half; base+1 is down/right
    function automatic bit move_axis(int base, int unsigned v);
        bit                lower;
        int                sel;
        logic [HALF_W-1:0] mag;
        lower = v < int'(AXIS_CENTER);
        sel = lower ? base : base + 1;
        mag = half_magnitude(lower, v);
        st_half[lower ? base + 1 : base] = '0;
        if (mag == st_half[sel])
            return 1'b0;
        st_half[sel] = mag;
        return 1'b1;
    endfunction

    function automatic pad_snapshot_t decode_event(logic [TYPE_W-1:0] et,
                                                  logic [CODE_W-1:0] ec,
                                                  logic [VALUE_W-1:0] ev);
        pad_snapshot_t snap;
        bit            upd;
        int            btn;
        int unsigned   level;
        upd = 1'b0;
        btn = -1;
        level = ev[VALUE_W-1] ? 0 : int'(ev[TRIG_W-1:0]);
        if (et != '0)
        begin
            upd = 1'b1;
            case (ec)
                CODE_BTN_B:     btn = 0;
                CODE_BTN_Y:     btn = 1;
                CODE_BTN_X:     btn = 2;
                CODE_BTN_A:     btn = 3;
                CODE_BTN_LB:    btn = 4;
                CODE_BTN_RB:    btn = 5;
                CODE_BTN_START: btn = 6;
                CODE_BTN_SEL:   btn = 7;
                CODE_BTN_HOME:  btn = 8;
                CODE_BTN_LPR:   btn = 9;
                CODE_BTN_RPR:   btn = 10;
                CODE_TRIG_L:    st_trig[0] = TRIG_W'(level);
                CODE_TRIG_R:    st_trig[1] = TRIG_W'(level);
                CODE_DPAD_Y:
                begin
                    st_dpad[1:0] = 2'b00;
                    if (ev == VAL_PLUS_ONE)
                        st_dpad[1] = 1'b1;
                    else if (ev == VAL_MINUS_ONE)
                        st_dpad[0] = 1'b1;
                end
                CODE_DPAD_X:
                begin
                    st_dpad[3:2] = 2'b00;
                    if (ev == VAL_PLUS_ONE)
                        st_dpad[3] = 1'b1;
                    else if (ev == VAL_MINUS_ONE)
                        st_dpad[2] = 1'b1;
                end
                CODE_AXIS_LY:   upd = move_axis(0, level);
                CODE_AXIS_LX:   upd = move_axis(2, level);
                CODE_AXIS_RY:   upd = move_axis(4, level);
                CODE_AXIS_RX:   upd = move_axis(6, level);
                default:        ;
            endcase
            if (btn >= 0)
                st_buttons[btn] = (ev != '0);
        end
        snap.buttons = {st_dpad, st_buttons};
        snap.ltrig = st_trig[0];
        snap.rtrig = st_trig[1];
        snap.half = st_half;
        snap.upd = upd;
        return snap;
    endfunction

    task automatic report_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    task automatic check_snapshot(pad_snapshot_t exp, pad_snapshot_t act);
        report_field("button_bits", exp.buttons, act.buttons);
        report_field("left_trigger", exp.ltrig, act.ltrig);
        report_field("right_trigger", exp.rtrig, act.rtrig);
        for (int i = 0; i < 8; i++)
            report_field(half_names[i], exp.half[i], act.half[i]);
        report_field("updated", exp.upd, act.upd);
    endtask

    // Caller must either send again or lower in_valid in the same time step
    task automatic send_event(logic [TYPE_W-1:0] et, logic [CODE_W-1:0] ec,
                              logic [VALUE_W-1:0] ev, bit typed, pad_snapshot_t typed_snap);
        pad_snapshot_t predicted;
        while (!steady && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        event_type <= et;
        event_code <= ec;
        event_value <= ev;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = decode_event(et, ec, ev);
        expected_snapshots.push_back(typed ? typed_snap : predicted);
        events_sent++;
        if (et == '0)
            sync_sent++;
    endtask

    task automatic drain_results;
        in_valid <= 1'b0;
        while (expected_snapshots.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_dz(logic [DZ_W-1:0] dz);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= dz;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_dz = dz;
        dz_writes++;
    endtask

    task automatic pick_event(output logic [TYPE_W-1:0] et, output logic [CODE_W-1:0] ec,
                              output logic [VALUE_W-1:0] ev);
        int k;
        int a;
        int c;
        et = TYPE_W'($urandom_range(1, 65535));
        ec = CODE_W'($urandom);
        ev = VALUE_W'($urandom);
        k = $urandom_range(0, 99);
        if (k < 6)
        begin
            et = '0;
            return;
        end
        if (k < 12)
            return;
        k = $urandom_range(0, 9);
        if (k < 3)
        begin
            ec = BUTTON_CODES[$urandom_range(0, 10)];
            k = $urandom_range(0, 9);
            if (k < 4)
                ev = '0;
            else if (k < 7)
                ev = VAL_PLUS_ONE;
        end
        else if (k == 3)
        begin
            ec = $urandom_range(0, 1) ? CODE_TRIG_L : CODE_TRIG_R;
            if ($urandom_range(0, 9) < 8)
                ev = VALUE_W'($urandom_range(0, 65535));
        end
        else if (k == 4)
        begin
            ec = $urandom_range(0, 1) ? CODE_DPAD_Y : CODE_DPAD_X;
            k = $urandom_range(0, 9);
            if (k < 3)
                ev = VAL_PLUS_ONE;
            else if (k < 6)
                ev = VAL_MINUS_ONE;
            else if (k < 8)
                ev = '0;
        end
        else
        begin
            a = $urandom_range(0, 3);
            ec = AXIS_CODES[a];
            k = $urandom_range(0, 9);
            if (k == 0)
                ev = last_axis_val[a];
            else if (k < 3)
            begin
                // land a few counts around either dead zone edge
                c = int'(AXIS_CENTER) + ($urandom_range(0, 1) ? int'(cur_dz)
                                                              : -int'(cur_dz));
                c = c + int'($urandom_range(0, 6)) - 3;
                if (c < 0)
                    c = 0;
                if (c > int'(AXIS_TOP))
                    c = int'(AXIS_TOP);
                ev = VALUE_W'(c);
            end
            else if (k == 3)
                ev = AXIS_EXTREMES[$urandom_range(0, 5)];
            else if (k < 8)
                ev = VALUE_W'($urandom_range(0, 65535));
            last_axis_val[a] = ev;
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 20);
    end

    always @(posedge clk)
    begin : result_monitor
        pad_snapshot_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.buttons = button_bits;
            seen.ltrig = left_trigger;
            seen.rtrig = right_trigger;
            seen.half = {right_stick_right, right_stick_left, right_stick_down, right_stick_up,
                         left_stick_right, left_stick_left, left_stick_down, left_stick_up};
            seen.upd = updated;
            if (expected_snapshots.size() == 0)
            begin
                errors++;
                $display("%0t: result with no event pending, expected none, actual %h",
                         $time, seen);
            end
            else
            begin
                check_snapshot(expected_snapshots.pop_front(), seen);
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [TYPE_W-1:0]  et;
        logic [CODE_W-1:0]  ec;
        logic [VALUE_W-1:0] ev;
        logic [DZ_W-1:0]    dz;
        int                 n;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        event_type = '0;
        event_code = '0;
        event_value = '0;
        cur_dz = DZ_RESET;
        st_buttons = '0;
        st_dpad = '0;
        st_trig[0] = '0;
        st_trig[1] = '0;
        st_half = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (DIRECTED_ROWS[i].wr_dz)
                write_dz(DIRECTED_ROWS[i].dz);
            send_event(DIRECTED_ROWS[i].etype, DIRECTED_ROWS[i].ecode,
                       DIRECTED_ROWS[i].evalue, DIRECTED_ROWS[i].typed,
                       DIRECTED_ROWS[i].exp);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       dz = DZ_RESET;
                1:       dz = 15'h7FFF;
                2:       dz = '0;
                3:       dz = 15'd32000;
                default: dz = DZ_W'($urandom_range(0, 32767));
            endcase
            // one phase runs back to back on both sides
            steady = (p == 2);
            write_dz(dz);
            n = 0;
            while (n < PHASE_EVENTS)
            begin
                pick_event(et, ec, ev);
                send_event(et, ec, ev, 1'b0, SNAP_NONE);
                if (et != '0)
                    n++;
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        $display("Sent %0d events (%0d sync) across %0d dead zone writes", events_sent,
                 sync_sent, dz_writes);
        $display("Checked %0d snapshots, %0d field mismatches", results_checked, errors);
        if (errors == 0 && expected_snapshots.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/ged_pkg.sv
hdl/gamepad_event_decoder_core.sv
hdl/gamepad_event_decoder_checker.sv
sim/testbench.sv
